// File: sv/sai_pkg.sv
// Shared constants and ctrl/datapath interface types for the atom index decompose unit
package sai_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int BLK_W      = 4;
   localparam int CNT_W      = 5;
   localparam int IDX_W      = 24;
   localparam int MOL_W      = 16;
   localparam int APM_W      = 12;
   localparam int PROD_W     = MOL_W + APM_W;
   localparam int SUM_W      = PROD_W + BLK_W;
   localparam int DIV_STEPS  = IDX_W;
   localparam int DIV_CNT_W  = 5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   typedef struct packed {
      logic       capture;     // latch the request beat
      logic       write_entry; // load the table entry
      logic       walk_start;  // clear block pointer and running end
      logic       walk_next;   // advance block pointer
      logic       read;        // registered table read at block pointer
      logic       mul;         // register block size
      logic       acc;         // add block size into running end
      logic       div_start;   // load divider with offset into block
      logic       div_step;    // one quotient bit
      logic       res_load;    // load result register
      logic [1:0] res_status;
   } sai_cmd_type;

   typedef struct packed {
      logic req_is_query;
      logic used_zero;
      logic hit;
      logic last;
      logic div_last;
   } sai_stat_type;

endpackage

// File: sv/segmented_atom_index_decompose_unit.sv
// Top level of the segmented atom index decompose unit
// A write beat (opcode 0) loads one entry of the 16-entry block table and answers with
// status 2. A query beat (opcode 1) walks the blocks from entry 0, each block taking a
// table read, a block size multiply and a running-end add and compare in turn, then
// runs a restoring divider on the offset into the hit block. An index past the N blocks
// in use, or any query while block_count is 0, is answered as out of range. One item is
// worked on at a time; a finished result sits in the output register while the next
// request is taken. block_count is written through csr_* and must only change while the
// unit is idle; table entries must be written before a query walks over them.
module segmented_atom_index_decompose_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sai_pkg::CNT_W-1:0]     csr_block_count,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [sai_pkg::BLK_W-1:0]     req_entry_index,
   input  logic [sai_pkg::MOL_W-1:0]     req_molecules_in_entry,
   input  logic [sai_pkg::APM_W-1:0]     req_atoms_per_molecule_in,
   input  logic [sai_pkg::IDX_W-1:0]     req_atom_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [sai_pkg::BLK_W-1:0]     rsp_block_found,
   output logic [sai_pkg::MOL_W-1:0]     rsp_molecule_in_block,
   output logic [sai_pkg::APM_W-1:0]     rsp_atom_in_molecule
);

   sai_pkg::sai_cmd_type  cmd;
   sai_pkg::sai_stat_type stat;

   assign csr_ready = 1'b1;

   sai_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sai_dpath u_dpath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .stat                      (stat),
      .csr_valid                 (csr_valid),
      .csr_block_count           (csr_block_count),
      .req_opcode                (req_opcode),
      .req_entry_index           (req_entry_index),
      .req_molecules_in_entry    (req_molecules_in_entry),
      .req_atoms_per_molecule_in (req_atoms_per_molecule_in),
      .req_atom_index            (req_atom_index),
      .rsp_status                (rsp_status),
      .rsp_block_found           (rsp_block_found),
      .rsp_molecule_in_block     (rsp_molecule_in_block),
      .rsp_atom_in_molecule      (rsp_atom_in_molecule)
   );

   // an accepted request takes the controller out of idle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken but controller still idle");

   // loading the result register always raises rsp_valid
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> rsp_valid)
      else $error("result loaded without rsp_valid");

   // only a successful query carries a decomposition
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != sai_pkg::ST_OK)) |->
         (rsp_block_found == '0 && rsp_molecule_in_block == '0 &&
          rsp_atom_in_molecule == '0))
      else $error("nonzero fields on a write or out-of-range result");

endmodule

// File: sv/sai_ctrl.sv
// Controller state machine: sequences table writes, the block walk and the divider
module sai_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sai_pkg::sai_stat_type stat,
   output sai_pkg::sai_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_MUL,
      S_ACC,
      S_DIV,
      S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      cmd             = '0;
      cmd.res_status  = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (stat.req_is_query) begin
                  cmd.walk_start = 1'b1;
                  if (stat.used_zero) begin
                     status_in = sai_pkg::ST_RANGE;
                     state_in  = S_OUT;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  state_in = S_WRITE;
               end
            end
         end
         S_WRITE: begin
            cmd.write_entry = 1'b1;
            status_in       = sai_pkg::ST_WRITE;
            state_in        = S_OUT;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            priority if (stat.hit) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (stat.last) begin
               status_in = sai_pkg::ST_RANGE;
               state_in  = S_OUT;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_READ;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               status_in = sai_pkg::ST_OK;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= sai_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/sai_dpath.sv
// Datapath: block table, size multiplier, running-end adder, restoring divider, result register
module sai_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  sai_pkg::sai_cmd_type              cmd,
   output sai_pkg::sai_stat_type             stat,
   input  logic                              csr_valid,
   input  logic [sai_pkg::CNT_W-1:0]         csr_block_count,
   input  logic                              req_opcode,
   input  logic [sai_pkg::BLK_W-1:0]         req_entry_index,
   input  logic [sai_pkg::MOL_W-1:0]         req_molecules_in_entry,
   input  logic [sai_pkg::APM_W-1:0]         req_atoms_per_molecule_in,
   input  logic [sai_pkg::IDX_W-1:0]         req_atom_index,
   output logic [1:0]                        rsp_status,
   output logic [sai_pkg::BLK_W-1:0]         rsp_block_found,
   output logic [sai_pkg::MOL_W-1:0]         rsp_molecule_in_block,
   output logic [sai_pkg::APM_W-1:0]         rsp_atom_in_molecule
);

   // block table, undefined until written
   logic [sai_pkg::MOL_W-1:0] mols_mem [sai_pkg::MAX_BLOCKS];
   logic [sai_pkg::APM_W-1:0] apm_mem  [sai_pkg::MAX_BLOCKS];

   logic [sai_pkg::CNT_W-1:0]  blk_count_ff;
   logic [sai_pkg::CNT_W-1:0]  used;

   logic [sai_pkg::BLK_W-1:0]  entry_ff;
   logic [sai_pkg::MOL_W-1:0]  mols_ff;
   logic [sai_pkg::APM_W-1:0]  apm_ff;
   logic [sai_pkg::IDX_W-1:0]  idx_ff;

   logic [sai_pkg::BLK_W-1:0]  blk_ff;
   logic [sai_pkg::MOL_W-1:0]  rd_mols_ff;
   logic [sai_pkg::APM_W-1:0]  rd_apm_ff;
   logic [sai_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [sai_pkg::SUM_W-1:0]  end_ff, end_in;

   logic [sai_pkg::IDX_W-1:0]     quo_ff, quo_in;
   logic [sai_pkg::APM_W-1:0]     rem_ff, rem_in;
   logic [sai_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [sai_pkg::APM_W:0]       partial;
   logic [sai_pkg::APM_W:0]       divisor;
   logic [sai_pkg::APM_W:0]       diff;
   logic [sai_pkg::IDX_W-1:0]     offset;

   logic [1:0]                rsp_status_ff;
   logic [sai_pkg::BLK_W-1:0] rsp_block_ff;
   logic [sai_pkg::MOL_W-1:0] rsp_mol_ff;
   logic [sai_pkg::APM_W-1:0] rsp_atom_ff;

   assign used = (blk_count_ff > sai_pkg::CNT_W'(sai_pkg::MAX_BLOCKS))
               ? sai_pkg::CNT_W'(sai_pkg::MAX_BLOCKS) : blk_count_ff;

   assign prod_in = {{(sai_pkg::PROD_W-sai_pkg::MOL_W){1'b0}}, rd_mols_ff}
                  * {{(sai_pkg::PROD_W-sai_pkg::APM_W){1'b0}}, rd_apm_ff};
   assign end_in  = end_ff + {{(sai_pkg::SUM_W-sai_pkg::PROD_W){1'b0}}, prod_ff};

   // previous blocks all missed, so the running end is at most the index
   assign offset = idx_ff - end_ff[sai_pkg::IDX_W-1:0];

   assign partial = {rem_ff, quo_ff[sai_pkg::IDX_W-1]};
   assign divisor = {1'b0, rd_apm_ff};
   assign diff    = partial - divisor;

   always_comb begin
      if (partial >= divisor) begin
         rem_in = diff[sai_pkg::APM_W-1:0];
         quo_in = {quo_ff[sai_pkg::IDX_W-2:0], 1'b1};
      end else begin
         rem_in = partial[sai_pkg::APM_W-1:0];
         quo_in = {quo_ff[sai_pkg::IDX_W-2:0], 1'b0};
      end
   end

   assign stat.req_is_query = (req_opcode == sai_pkg::OP_QUERY);
   assign stat.used_zero    = (blk_count_ff == '0);
   assign stat.hit          = ({{(sai_pkg::SUM_W-sai_pkg::IDX_W){1'b0}}, idx_ff} < end_in);
   assign stat.last         = ((sai_pkg::CNT_W'(blk_ff) + sai_pkg::CNT_W'(1)) == used);
   assign stat.div_last     = (div_cnt_ff == sai_pkg::DIV_CNT_W'(sai_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_count_ff <= sai_pkg::CNT_W'(1);
      end else if (csr_valid) begin
         blk_count_ff <= csr_block_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mols_mem[entry_ff] <= mols_ff;
         apm_mem[entry_ff]  <= apm_ff;
      end
      if (cmd.read) begin
         rd_mols_ff <= mols_mem[blk_ff];
         rd_apm_ff  <= apm_mem[blk_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_ff <= req_entry_index;
         mols_ff  <= req_molecules_in_entry;
         apm_ff   <= req_atoms_per_molecule_in;
         idx_ff   <= req_atom_index;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.div_start) begin
         quo_ff <= offset;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (cmd.res_load) begin
         rsp_status_ff <= cmd.res_status;
         if (cmd.res_status == sai_pkg::ST_OK) begin
            rsp_block_ff <= blk_ff;
            rsp_mol_ff   <= quo_ff[sai_pkg::MOL_W-1:0];
            rsp_atom_ff  <= rem_ff;
         end else begin
            rsp_block_ff <= '0;
            rsp_mol_ff   <= '0;
            rsp_atom_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff     <= '0;
         end_ff     <= '0;
         div_cnt_ff <= '0;
      end else begin
         if (cmd.walk_start) begin
            blk_ff <= '0;
            end_ff <= '0;
         end else begin
            if (cmd.walk_next) begin
               blk_ff <= blk_ff + sai_pkg::BLK_W'(1);
            end
            if (cmd.acc) begin
               end_ff <= end_in;
            end
         end
         if (cmd.div_start) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + sai_pkg::DIV_CNT_W'(1);
         end
      end
   end

   assign rsp_status            = rsp_status_ff;
   assign rsp_block_found       = rsp_block_ff;
   assign rsp_molecule_in_block = rsp_mol_ff;
   assign rsp_atom_in_molecule  = rsp_atom_ff;

endmodule
